// File: src/indexed_array_insert_delete_core_defines.svh
// Assertion helpers shared by the core
`ifndef INDEXED_ARRAY_INSERT_DELETE_CORE_DEFINES_SVH
`define INDEXED_ARRAY_INSERT_DELETE_CORE_DEFINES_SVH

// Check a consequence in the same cycle
`define IAID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle
`define IAID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/iaid_pkg.sv
package iaid_pkg;

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned POS_W    = 11;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned COUNT_W  = 11;

  // Stream word widths
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 16;
  localparam int unsigned S_PAD_W   = S_TDATA_W - POS_W - VAL_W;
  localparam int unsigned M_PAD_W   = M_TDATA_W - STAT_W - 1 - COUNT_W;

  localparam int unsigned DEFAULT_CAPACITY = 1024;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

// File: src/indexed_array_insert_delete_core.sv
// Channel  | Direction | Word layout, lowest bit first
// s_*      | in        | tdata: position[10:0], item_value[42:11]; tuser: opcode[1:0]
// m_*      | out       | tdata: status[1:0], found[2], element_count[13:3]
//
// Delete and insert walk the moved elements and search walks every element; insert then writes the new value.
// Errors, clear, empty search and deleting the last element skip the walk; insert at the end only writes.
// The walk is set by the single read port and single write port of the store.
// rst clears the element count; stored words are not cleared.
// A result held in the output register stalls the next finish, not acceptance.
`include "indexed_array_insert_delete_core_defines.svh"

module indexed_array_insert_delete_core #(
  parameter int unsigned CAPACITY = iaid_pkg::DEFAULT_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // position[10:0], item_value[42:11], zero pad
  input  logic [iaid_pkg::S_TDATA_W-1:0]   s_tdata,
  // opcode[1:0]
  input  logic [iaid_pkg::OP_W-1:0]        s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status[1:0], found[2], element_count[13:3], zero pad
  output logic [iaid_pkg::M_TDATA_W-1:0]   m_tdata
);
  import iaid_pkg::*;

  localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

  cmd_t               cmd;
  res_t               res;
  logic               start;
  logic               eng_idle;
  logic               eng_done;
  logic               res_ready;
  logic [STAT_W-1:0]  status_q;
  logic               found_q;
  logic [COUNT_W-1:0] count_q;
  logic               full_seen;

  // Unpack the input word
  assign cmd.op    = s_tuser;
  assign cmd.pos   = s_tdata[POS_W-1:0];
  assign cmd.value = s_tdata[POS_W +: VAL_W];

  assign s_tready  = eng_idle;
  assign start     = s_tvalid && s_tready;
  assign res_ready = !m_tvalid || m_tready;

  iaid_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .idle      (eng_idle),
    .done      (eng_done),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load a finished result, hold it until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (eng_done && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done && res_ready) begin
      status_q <= res.status;
      found_q  <= res.found;
      count_q  <= res.count;
    end
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, count_q, found_q, status_q};

  assign full_seen = m_tvalid && (status_q == ST_FULL);

  `IAID_ASSERT_NOW(a_count_bound, m_tvalid, count_q <= CAP_COUNT, "element count above capacity")
  `IAID_ASSERT_NOW(a_full_count, full_seen, count_q == CAP_COUNT, "full status, table not full")
  `IAID_ASSERT_NEXT(a_busy_after_accept, start, !s_tready, "ready right after an accepted word")

endmodule

// File: src/iaid_engine.sv
module iaid_engine #(
  parameter int unsigned CAPACITY = iaid_pkg::DEFAULT_CAPACITY
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  iaid_pkg::cmd_t cmd,
  output logic           idle,
  output logic           done,
  input  logic           res_ready,
  output iaid_pkg::res_t res
);
  import iaid_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_FILL   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]        state;
  logic [CW-1:0]     count;
  logic [OP_W-1:0]   op;
  logic [VAL_W-1:0]  value;
  logic [AW-1:0]     fill_addr;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     last;
  logic [AW-1:0]     pend_addr;
  logic              issuing;
  logic              pend;
  logic [STAT_W-1:0] status;
  logic              found;

  logic [VAL_W-1:0]  mem [CAPACITY];
  logic [VAL_W-1:0]  rdata;
  logic              re;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [VAL_W-1:0]  wdata;

  logic [XW-1:0]     cnt_x;
  logic [XW-1:0]     pos_x;

  assign cnt_x = XW'(count);
  assign pos_x = XW'(cmd.pos);

  // Sequencer: decode, walk the live range, fill, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      issuing <= 1'b0;
      pend    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op        <= cmd.op;
            value     <= cmd.value;
            status    <= ST_DONE;
            found     <= 1'b0;
            fill_addr <= AW'(pos_x);
            pend      <= 1'b0;
            unique case (cmd.op)
              OP_INSERT: begin
                if (pos_x > cnt_x) begin
                  status <= ST_RANGE;
                  state  <= S_FINISH;
                end else if (count == CW'(CAPACITY)) begin
                  status <= ST_FULL;
                  state  <= S_FINISH;
                end else begin
                  count <= count + 1'b1;
                  if (pos_x == cnt_x) begin
                    state <= S_FILL;
                  end else begin
                    ptr     <= AW'(cnt_x - 1'b1);
                    last    <= AW'(pos_x);
                    issuing <= 1'b1;
                    state   <= S_WALK;
                  end
                end
              end
              OP_DELETE: begin
                if (pos_x >= cnt_x) begin
                  status <= ST_RANGE;
                  state  <= S_FINISH;
                end else begin
                  count <= count - 1'b1;
                  if (pos_x == cnt_x - 1'b1) begin
                    state <= S_FINISH;
                  end else begin
                    ptr     <= AW'(pos_x + 1'b1);
                    last    <= AW'(cnt_x - 1'b1);
                    issuing <= 1'b1;
                    state   <= S_WALK;
                  end
                end
              end
              OP_SEARCH: begin
                if (count == '0) begin
                  state <= S_FINISH;
                end else begin
                  ptr     <= '0;
                  last    <= AW'(cnt_x - 1'b1);
                  issuing <= 1'b1;
                  state   <= S_WALK;
                end
              end
              default: begin
                count <= '0;
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_WALK: begin
          // Issue one read per cycle; the data comes back in the next cycle
          if (issuing) begin
            pend      <= 1'b1;
            pend_addr <= ptr;
            if (ptr == last) begin
              issuing <= 1'b0;
            end else if (op == OP_INSERT) begin
              ptr <= ptr - 1'b1;
            end else begin
              ptr <= ptr + 1'b1;
            end
          end else begin
            pend <= 1'b0;
            if (pend) begin
              state <= (op == OP_INSERT) ? S_FILL : S_FINISH;
            end
          end
          if (pend && op == OP_SEARCH && rdata == value) begin
            found <= 1'b1;
          end
        end
        S_FILL: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Select the write: move the returned word, or drop in the new value
  always_comb begin
    re    = (state == S_WALK) && issuing;
    we    = 1'b0;
    waddr = fill_addr;
    wdata = value;
    if (state == S_FILL) begin
      we = 1'b1;
    end else if (state == S_WALK && pend && op != OP_SEARCH) begin
      we    = 1'b1;
      wdata = rdata;
      waddr = (op == OP_INSERT) ? pend_addr + 1'b1 : pend_addr - 1'b1;
    end
  end

  // Element store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[ptr];
    end
  end

  assign idle       = (state == S_IDLE);
  assign done       = (state == S_FINISH);
  assign res.status = status;
  assign res.found  = found;
  assign res.count  = COUNT_W'(count);

endmodule
